@@ rtl/sbcr_pkg.sv @@
// Shared constants and codes for the spectrum bar column renderer.
package sbcr_pkg;

    localparam int BAND_W       = 6;
    localparam int MAG_W        = 16;
    localparam int COLUMN_W     = 7;
    localparam int MASK_W       = 40;
    localparam int HEIGHT_OUT_W = 6;
    localparam int PEAK_ROW_W   = 6;

    localparam int SCALE_W      = 7;
    localparam int HEIGHT_SCALE = 120;
    localparam int SCALE_SHIFT  = 12;

    localparam int TENTHS       = 10;
    localparam int PEAK_FALL    = 4;

    // Floor division by ten as a multiply by 205 and a shift by 11.
    localparam int DIV10_MUL_W  = 8;
    localparam int DIV10_MUL    = 205;
    localparam int DIV10_SHIFT  = 11;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAKS_EN  = 1'd1;

    localparam logic [1:0] DRAW_CLASSIC = 2'd0;
    localparam logic [1:0] DRAW_MIRROR  = 2'd1;
    localparam logic [1:0] DRAW_DOT     = 2'd2;

endpackage

@@ rtl/sbcr_in_if.sv @@
// Input channel carrying one band magnitude beat.
interface sbcr_in_if;
    logic                          valid;
    logic                          ready;
    logic [sbcr_pkg::BAND_W-1:0]   band_index;
    logic [sbcr_pkg::MAG_W-1:0]    magnitude;

    modport source (output valid, output band_index, output magnitude, input ready);
    modport sink   (input valid, input band_index, input magnitude, output ready);
endinterface

@@ rtl/sbcr_out_if.sv @@
// Output channel carrying one rendered column beat.
interface sbcr_out_if;
    logic                                valid;
    logic                                ready;
    logic [sbcr_pkg::COLUMN_W-1:0]       column;
    logic [sbcr_pkg::MASK_W-1:0]         pixel_mask;
    logic [sbcr_pkg::HEIGHT_OUT_W-1:0]   bar_height;
    logic [sbcr_pkg::PEAK_ROW_W-1:0]     peak_row;

    modport source (output valid, output column, output pixel_mask, output bar_height,
                    output peak_row, input ready);
    modport sink   (input valid, input column, input pixel_mask, input bar_height,
                    input peak_row, output ready);
endinterface

@@ rtl/sbcr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sbcr_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sbcr_height.sv @@
// Input register stage and saturated bar height computation.
module sbcr_height #(
    parameter int BAND_COUNT = 64,
    parameter int ROW_COUNT  = 40
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sbcr_in_if.sink                            i_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [sbcr_pkg::BAND_W-1:0]        o_band,
    output logic [$clog2(ROW_COUNT+1)-1:0]     o_height
);

    localparam int HW     = $clog2(ROW_COUNT + 1);
    localparam int PROD_W = sbcr_pkg::MAG_W + sbcr_pkg::SCALE_W;
    localparam int Q_W    = PROD_W - sbcr_pkg::SCALE_SHIFT;

    logic                        r_valid;
    logic [sbcr_pkg::BAND_W-1:0] r_band;
    logic [sbcr_pkg::MAG_W-1:0]  r_mag;
    logic                        fire;
    logic                        in_range;
    logic [PROD_W-1:0]           prod;
    logic [Q_W-1:0]              quot;

    assign i_in.ready = !r_valid || i_ready;
    assign fire       = i_in.valid && i_in.ready;
    assign in_range   = ({1'b0, i_in.band_index} < (sbcr_pkg::BAND_W + 1)'(BAND_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= fire && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_band <= i_in.band_index;
            r_mag  <= i_in.magnitude;
        end
    end

    assign prod = PROD_W'(r_mag) * PROD_W'(sbcr_pkg::HEIGHT_SCALE);
    assign quot = prod[PROD_W-1:sbcr_pkg::SCALE_SHIFT];

    assign o_valid  = r_valid;
    assign o_band   = r_band;
    assign o_height = (quot > Q_W'(ROW_COUNT)) ? HW'(ROW_COUNT) : HW'(quot);

endmodule

@@ rtl/sbcr_peak.sv @@
// Peak hold read-modify-write stages with write forwarding and reset valid bits.
module sbcr_peak #(
    parameter int BAND_COUNT = 64,
    parameter int ROW_COUNT  = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_peaks_en,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [sbcr_pkg::BAND_W-1:0]            i_band,
    input  logic [$clog2(ROW_COUNT+1)-1:0]         i_height,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [sbcr_pkg::BAND_W-1:0]            o_band,
    output logic [$clog2(ROW_COUNT+1)-1:0]         o_height,
    output logic [$clog2(ROW_COUNT*10+1)-1:0]      o_peak
);

    localparam int HW = $clog2(ROW_COUNT + 1);
    localparam int PW = $clog2(ROW_COUNT * sbcr_pkg::TENTHS + 1);
    localparam int AW = $clog2(BAND_COUNT);

    logic                        r_s2_valid;
    logic [sbcr_pkg::BAND_W-1:0] r_s2_band;
    logic [HW-1:0]               r_s2_height;
    logic                        r_s2_fwd;
    logic [PW-1:0]               r_s2_fwd_peak;
    logic                        r_s2_vbit;

    logic                        r_s3_valid;
    logic [sbcr_pkg::BAND_W-1:0] r_s3_band;
    logic [HW-1:0]               r_s3_height;
    logic [PW-1:0]               r_s3_peak;

    logic [BAND_COUNT-1:0]       r_vbits;

    logic                        s3_ready;
    logic                        fire_in;
    logic                        fire_s2;
    logic                        wr_en;
    logic [PW-1:0]               ram_q;
    logic [PW-1:0]               old_peak;
    logic [PW-1:0]               target;
    logic [PW-1:0]               new_peak;
    logic [PW-1:0]               used_peak;

    assign s3_ready = !r_s3_valid || i_ready;
    assign o_ready  = !r_s2_valid || s3_ready;
    assign fire_in  = i_valid && o_ready;
    assign fire_s2  = r_s2_valid && s3_ready;
    assign wr_en    = fire_s2 && i_peaks_en;

    assign old_peak = r_s2_fwd ? r_s2_fwd_peak : (r_s2_vbit ? ram_q : '0);
    assign target   = PW'(r_s2_height) * PW'(sbcr_pkg::TENTHS);

    always_comb begin
        if (target > old_peak) begin
            new_peak = target;
        end else if (old_peak > PW'(sbcr_pkg::PEAK_FALL)) begin
            new_peak = old_peak - PW'(sbcr_pkg::PEAK_FALL);
        end else begin
            new_peak = '0;
        end
    end

    assign used_peak = i_peaks_en ? new_peak : old_peak;

    sbcr_ram #(
        .WIDTH (PW),
        .DEPTH (BAND_COUNT)
    ) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s2_band[AW-1:0]),
        .i_wdata (new_peak),
        .i_re    (fire_in),
        .i_raddr (i_band[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_vbits    <= '0;
        end else begin
            if (o_ready) begin
                r_s2_valid <= i_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (wr_en) begin
                r_vbits[r_s2_band[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_in) begin
            r_s2_band     <= i_band;
            r_s2_height   <= i_height;
            r_s2_fwd      <= wr_en && (r_s2_band == i_band);
            r_s2_fwd_peak <= new_peak;
            r_s2_vbit     <= r_vbits[i_band[AW-1:0]];
        end
        if (fire_s2) begin
            r_s3_band   <= r_s2_band;
            r_s3_height <= r_s2_height;
            r_s3_peak   <= used_peak;
        end
    end

    assign o_valid  = r_s3_valid;
    assign o_band   = r_s3_band;
    assign o_height = r_s3_height;
    assign o_peak   = r_s3_peak;

endmodule

@@ rtl/sbcr_draw.sv @@
// Peak row, column placement and pixel mask stages feeding the output register.
module sbcr_draw #(
    parameter int BAND_COUNT = 64,
    parameter int ROW_COUNT  = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [1:0]                             i_draw_mode,
    input  logic                                   i_peaks_en,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [sbcr_pkg::BAND_W-1:0]            i_band,
    input  logic [$clog2(ROW_COUNT+1)-1:0]         i_height,
    input  logic [$clog2(ROW_COUNT*10+1)-1:0]      i_peak,
    sbcr_out_if.source                             o_out
);

    localparam int HW     = $clog2(ROW_COUNT + 1);
    localparam int PW     = $clog2(ROW_COUNT * sbcr_pkg::TENTHS + 1);
    localparam int RW     = $clog2(ROW_COUNT);
    localparam int DW     = PW + sbcr_pkg::DIV10_MUL_W;
    localparam int XW     = sbcr_pkg::BAND_W + 2;
    localparam int IW     = 8;
    localparam int CENTER = BAND_COUNT / 2;

    logic                          r_s4_valid;
    logic [sbcr_pkg::COLUMN_W-1:0] r_s4_column;
    logic [HW-1:0]                 r_s4_height;
    logic [RW-1:0]                 r_s4_peak_row;

    logic                              r_out_valid;
    logic [sbcr_pkg::COLUMN_W-1:0]     r_out_column;
    logic [sbcr_pkg::MASK_W-1:0]       r_out_mask;
    logic [sbcr_pkg::HEIGHT_OUT_W-1:0] r_out_height;
    logic [sbcr_pkg::PEAK_ROW_W-1:0]   r_out_peak_row;

    logic                          out_ready;
    logic [DW-1:0]                 div_prod;
    logic [HW-1:0]                 whole;
    logic [RW-1:0]                 peak_row;
    logic [XW-1:0]                 off;
    logic [XW-1:0]                 mirror_x;
    logic [sbcr_pkg::COLUMN_W-1:0] column;
    logic [HW-1:0]                 top_row;
    logic [sbcr_pkg::MASK_W-1:0]   mask;

    assign out_ready = !r_out_valid || o_out.ready;
    assign o_ready   = !r_s4_valid || out_ready;

    assign div_prod = DW'(i_peak) * DW'(sbcr_pkg::DIV10_MUL);
    assign whole    = HW'(div_prod >> sbcr_pkg::DIV10_SHIFT);
    assign peak_row = (whole >= HW'(ROW_COUNT - 1)) ? '0 : RW'(HW'(ROW_COUNT - 1) - whole);

    assign off      = XW'(i_band >> 1);
    assign mirror_x = i_band[0] ? (XW'(CENTER) - off - XW'(1)) : (XW'(CENTER) + off);
    assign column   = (i_draw_mode == sbcr_pkg::DRAW_MIRROR)
                    ? sbcr_pkg::COLUMN_W'(mirror_x << 1)
                    : sbcr_pkg::COLUMN_W'(XW'(i_band) << 1);

    assign top_row = HW'(ROW_COUNT) - r_s4_height;

    always_comb begin
        mask = '0;
        for (int i = 0; i < sbcr_pkg::MASK_W; i++) begin
            if (i < ROW_COUNT) begin
                if (i_draw_mode == sbcr_pkg::DRAW_CLASSIC ||
                    i_draw_mode == sbcr_pkg::DRAW_MIRROR) begin
                    mask[i] = (IW'(i) >= IW'(top_row)) ||
                              (i_peaks_en && (IW'(r_s4_peak_row) == IW'(i)));
                end else if (i_draw_mode == sbcr_pkg::DRAW_DOT) begin
                    mask[i] = (r_s4_height != '0) && (IW'(top_row) == IW'(i));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s4_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s4_column   <= column;
            r_s4_height   <= i_height;
            r_s4_peak_row <= peak_row;
        end
        if (r_s4_valid && out_ready) begin
            r_out_column   <= r_s4_column;
            r_out_mask     <= mask;
            r_out_height   <= sbcr_pkg::HEIGHT_OUT_W'(r_s4_height);
            r_out_peak_row <= sbcr_pkg::PEAK_ROW_W'(r_s4_peak_row);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.column     = r_out_column;
    assign o_out.pixel_mask = r_out_mask;
    assign o_out.bar_height = r_out_height;
    assign o_out.peak_row   = r_out_peak_row;

endmodule

@@ rtl/spectrum_bar_column_renderer_unit.sv @@
// Top level of the spectrum bar column renderer with per-band peak hold.
// A beat passes the input, peak read, peak result, placement and output registers.
// One beat per cycle unless stalled; the peak RAM takes one read and one write per cycle.
// Reset clears all peaks at once through per-band valid bits, with no clearing pass.
// Reset sets draw_mode to classic bars and turns peaks on.
module spectrum_bar_column_renderer_unit #(
    parameter int BAND_COUNT = 64,
    parameter int ROW_COUNT  = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sbcr_in_if.sink                           i_in,
    sbcr_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [sbcr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbcr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int HW = $clog2(ROW_COUNT + 1);
    localparam int PW = $clog2(ROW_COUNT * sbcr_pkg::TENTHS + 1);

    logic [1:0]                  r_draw_mode;
    logic                        r_peaks_en;

    logic                        h_valid;
    logic                        h_ready;
    logic [sbcr_pkg::BAND_W-1:0] h_band;
    logic [HW-1:0]               h_height;

    logic                        p_valid;
    logic                        p_ready;
    logic [sbcr_pkg::BAND_W-1:0] p_band;
    logic [HW-1:0]               p_height;
    logic [PW-1:0]               p_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_mode <= sbcr_pkg::DRAW_CLASSIC;
            r_peaks_en  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbcr_pkg::CFG_DRAW_MODE: r_draw_mode <= i_cfg_data[1:0];
                sbcr_pkg::CFG_PEAKS_EN:  r_peaks_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sbcr_height #(
        .BAND_COUNT (BAND_COUNT),
        .ROW_COUNT  (ROW_COUNT)
    ) u_height (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_valid  (h_valid),
        .i_ready  (h_ready),
        .o_band   (h_band),
        .o_height (h_height)
    );

    sbcr_peak #(
        .BAND_COUNT (BAND_COUNT),
        .ROW_COUNT  (ROW_COUNT)
    ) u_peak (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_peaks_en (r_peaks_en),
        .i_valid    (h_valid),
        .o_ready    (h_ready),
        .i_band     (h_band),
        .i_height   (h_height),
        .o_valid    (p_valid),
        .i_ready    (p_ready),
        .o_band     (p_band),
        .o_height   (p_height),
        .o_peak     (p_peak)
    );

    sbcr_draw #(
        .BAND_COUNT (BAND_COUNT),
        .ROW_COUNT  (ROW_COUNT)
    ) u_draw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_draw_mode (r_draw_mode),
        .i_peaks_en  (r_peaks_en),
        .i_valid     (p_valid),
        .o_ready     (p_ready),
        .i_band      (p_band),
        .i_height    (p_height),
        .i_peak      (p_peak),
        .o_out       (o_out)
    );

endmodule

@@ tb/sv/sbcr_column_checker.sv @@
// Checker that predicts every rendered column and compares it with the output channel.
module sbcr_column_checker #(
    parameter int BAND_COUNT = 64,
    parameter int ROW_COUNT  = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sbcr_in_if                                i_in_mon,
    sbcr_out_if                               i_out_mon,
    input  logic                              i_cfg_we,
    input  logic [sbcr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbcr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_mismatches,
    output int                                o_pending
);
    import sbcr_pkg::*;

    typedef struct packed {
        logic [COLUMN_W-1:0]     column;
        logic [MASK_W-1:0]       pixel_mask;
        logic [HEIGHT_OUT_W-1:0] bar_height;
        logic [PEAK_ROW_W-1:0]   peak_row;
    } column_beat_t;

    localparam int CENTER = BAND_COUNT / 2;

    logic [1:0]   draw_mode;
    logic         peaks_on;
    logic [8:0]   peak_hold_tenths [BAND_COUNT];
    column_beat_t expected_columns [$];
    int           mismatch_count;

    function automatic column_beat_t render_column(logic [BAND_W-1:0] band,
                                                   logic [MAG_W-1:0] mag);
        column_beat_t beat;
        int unsigned  height;
        int unsigned  tenths;
        int unsigned  whole;
        int unsigned  prow;
        int unsigned  x;
        logic [MASK_W-1:0] mask;
        height = (int'(mag) * HEIGHT_SCALE) >> SCALE_SHIFT;
        if (height > ROW_COUNT) begin
            height = ROW_COUNT;
        end
        tenths = peak_hold_tenths[band];
        if (peaks_on) begin
            if (height * TENTHS > tenths) begin
                tenths = height * TENTHS;
            end else if (tenths > PEAK_FALL) begin
                tenths = tenths - PEAK_FALL;
            end else begin
                tenths = 0;
            end
            peak_hold_tenths[band] = 9'(tenths);
        end
        whole = tenths / TENTHS;
        prow = (whole >= ROW_COUNT - 1) ? 0 : ROW_COUNT - 1 - whole;
        if (draw_mode == DRAW_MIRROR) begin
            x = band[0] ? CENTER - band / 2 - 1 : CENTER + band / 2;
        end else begin
            x = band;
        end
        mask = '0;
        if (draw_mode == DRAW_CLASSIC || draw_mode == DRAW_MIRROR) begin
            if (height != 0) begin
                mask = {MASK_W{1'b1}} << (ROW_COUNT - height);
            end
            if (peaks_on) begin
                mask[prow] = 1'b1;
            end
        end else if (draw_mode == DRAW_DOT && height != 0) begin
            mask[ROW_COUNT - height] = 1'b1;
        end
        beat.column     = COLUMN_W'(2 * x);
        beat.pixel_mask = mask;
        beat.bar_height = HEIGHT_OUT_W'(height);
        beat.peak_row   = PEAK_ROW_W'(prow);
        return beat;
    endfunction

    initial begin
        mismatch_count = 0;
        o_mismatches   = 0;
        o_pending      = 0;
        draw_mode      = DRAW_CLASSIC;
        peaks_on       = 1'b1;
        foreach (peak_hold_tenths[i]) peak_hold_tenths[i] = '0;
    end

    always @(posedge i_clk) begin
        column_beat_t want;
        if (!i_rst_n) begin
            draw_mode = DRAW_CLASSIC;
            peaks_on  = 1'b1;
            foreach (peak_hold_tenths[i]) peak_hold_tenths[i] = '0;
            expected_columns.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_columns.size() == 0) begin
                    $error("unexpected output beat: column %0d", i_out_mon.column);
                    mismatch_count++;
                end else begin
                    want = expected_columns.pop_front();
                    if (i_out_mon.column !== want.column) begin
                        $error("column: expected %0d, actual %0d",
                               want.column, i_out_mon.column);
                        mismatch_count++;
                    end
                    if (i_out_mon.pixel_mask !== want.pixel_mask) begin
                        $error("pixel_mask: expected %h, actual %h",
                               want.pixel_mask, i_out_mon.pixel_mask);
                        mismatch_count++;
                    end
                    if (i_out_mon.bar_height !== want.bar_height) begin
                        $error("bar_height: expected %0d, actual %0d",
                               want.bar_height, i_out_mon.bar_height);
                        mismatch_count++;
                    end
                    if (i_out_mon.peak_row !== want.peak_row) begin
                        $error("peak_row: expected %0d, actual %0d",
                               want.peak_row, i_out_mon.peak_row);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready && i_in_mon.band_index < BAND_COUNT) begin
                expected_columns.push_back(render_column(i_in_mon.band_index,
                                                         i_in_mon.magnitude));
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DRAW_MODE) begin
                    draw_mode = i_cfg_data[1:0];
                end else if (i_cfg_idx == CFG_PEAKS_EN) begin
                    peaks_on = i_cfg_data[0];
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_columns.size();
    end

endmodule

@@ tb/sv/spectrum_bar_column_renderer_unit_tb.sv @@
// Testbench top: drives band magnitudes and register writes, and gives the verdict.
module spectrum_bar_column_renderer_unit_tb;
    import sbcr_pkg::*;

    localparam logic [1:0] DRAW_BLANK  = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         PHASES      = 10;
    localparam int         PHASE_BEATS = 85;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic gaps_on;
    int   mismatches;
    int   pending;
    int   idle_cycles;

    sbcr_in_if  band_ch ();
    sbcr_out_if col_ch ();

    spectrum_bar_column_renderer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (band_ch),
        .o_out      (col_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    sbcr_column_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (band_ch),
        .i_out_mon    (col_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        col_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            col_ch.ready <= !(gaps_on && $urandom_range(99) < 18);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((band_ch.valid && band_ch.ready) || (col_ch.valid && col_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_band(input logic [BAND_W-1:0] band, input logic [MAG_W-1:0] mag);
        while (gaps_on && $urandom_range(99) < 18) begin
            band_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        band_ch.valid      <= 1'b1;
        band_ch.band_index <= band;
        band_ch.magnitude  <= mag;
        @(posedge i_clk);
        while (!band_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_columns();
        band_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic peaks);
        drain_columns();
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DRAW_MODE;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PEAKS_EN;
        i_cfg_data <= {1'($urandom_range(1)), peaks};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_random_band(input int mag_cap);
        logic [BAND_W-1:0] band;
        logic [MAG_W-1:0]  mag;
        int sel;
        sel = $urandom_range(99);
        band = (sel < 60) ? BAND_W'($urandom_range(7)) : BAND_W'($urandom_range(63));
        sel = $urandom_range(99);
        if (sel < 70) begin
            mag = MAG_W'($urandom_range(mag_cap));
        end else if (sel < 85) begin
            mag = MAG_W'($urandom_range(65535));
        end else if (sel < 95) begin
            mag = '0;
        end else begin
            mag = '1;
        end
        send_band(band, mag);
    endtask

    initial begin
        logic [1:0] mode;
        logic       peaks;
        int         cap;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_DRAW_MODE;
        i_cfg_data         <= '0;
        band_ch.valid      <= 1'b0;
        band_ch.band_index <= '0;
        band_ch.magnitude  <= '0;
        gaps_on            <= 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: classic bars with peaks on.
        send_band(6'd0, 16'd0);
        send_band(6'd63, 16'hFFFF);
        send_band(6'd1, 16'd34);
        send_band(6'd2, 16'd35);
        send_band(6'd3, 16'd1365);
        send_band(6'd4, 16'd1366);
        send_band(6'd63, 16'd0);
        send_band(6'd63, 16'd0);
        send_band(6'd4, 16'd0);
        configure(DRAW_MIRROR, 1'b1);
        send_band(6'd0, 16'd1000);
        send_band(6'd1, 16'hFFFF);
        send_band(6'd62, 16'd500);
        send_band(6'd63, 16'd20);
        configure(DRAW_DOT, 1'b1);
        send_band(6'd0, 16'd0);
        send_band(6'd5, 16'd35);
        send_band(6'd6, 16'hFFFF);
        send_band(6'd63, 16'd700);
        configure(DRAW_BLANK, 1'b1);
        send_band(6'd7, 16'd900);
        send_band(6'd63, 16'hFFFF);
        configure(DRAW_CLASSIC, 1'b0);
        send_band(6'd63, 16'd0);
        send_band(6'd4, 16'd2000);
        send_band(6'd10, 16'd0);
        configure(DRAW_MIRROR, 1'b0);
        send_band(6'd1, 16'd0);
        send_band(6'd62, 16'hFFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    mode = DRAW_CLASSIC;
                    peaks = 1'b1;
                end
                1: begin
                    mode = DRAW_DOT;
                    peaks = 1'b0;
                end
                2: begin
                    mode = DRAW_BLANK;
                    peaks = 1'b1;
                end
                3: begin
                    mode = DRAW_MIRROR;
                    peaks = 1'b1;
                end
                default: begin
                    mode = 2'($urandom_range(3));
                    peaks = 1'($urandom_range(1));
                end
            endcase
            case ($urandom_range(2))
                0: cap = 300;
                1: cap = 1500;
                default: cap = 65535;
            endcase
            configure(mode, peaks);
            gaps_on <= (ph != 3);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (ph == 6 && n == PHASE_BEATS / 2) begin
                    drain_columns();
                end
                send_random_band(cap);
            end
        end

        drain_columns();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
